// ----- design/taqs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the timed action queue sequencer.
// No dependencies; imported by the controller, datapath and top level.
package taqs_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  localparam int unsigned ArgW    = 16;
  localparam int unsigned DurW    = 16;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ActW    = 2;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned SDataW  = 72;  // 66 field bits, padded to bytes
  localparam int unsigned MDataW  = 56;  // 50 field bits, padded to bytes
  localparam int unsigned EntryW  = ActW + DurW + 3 * ArgW;

  // input item kinds (carried on s_axis_tuser)
  localparam logic [KindW-1:0] KIND_TICK    = 2'd0;
  localparam logic [KindW-1:0] KIND_CLEAR   = 2'd1;
  localparam logic [KindW-1:0] KIND_ENQUEUE = 2'd2;
  localparam logic [KindW-1:0] KIND_START   = 2'd3;

  // queued action types
  localparam logic [ActW-1:0] ACT_MOVE  = 2'd0;
  localparam logic [ActW-1:0] ACT_STOP  = 2'd1;
  localparam logic [ActW-1:0] ACT_SERVO = 2'd2;
  localparam logic [ActW-1:0] ACT_DELAY = 2'd3;

  // issued commands (carried on m_axis_tuser)
  localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
  localparam logic [CmdW-1:0] CMD_MOVE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 2'd2;
  localparam logic [CmdW-1:0] CMD_SERVO = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_FETCH   = 6'b000010,
    ST_EVAL    = 6'b000100,
    ST_REFETCH = 6'b001000,
    ST_ISSUE   = 6'b010000,
    ST_SEND    = 6'b100000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;   // input transaction this cycle
    logic eval;   // tick evaluation against the head entry
    logic issue;  // issue the head entry
    logic pop;    // output transaction this cycle
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_fetch;  // accepted item must look at the head entry
    logic was_start;   // item in flight is a start
    logic advance;     // entry ended and another one follows
    logic final_res;   // result on the output is the last of the item
  } stat_t;

endpackage

// ----- design/taqs_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine of the timed action queue sequencer.
// Depends on taqs_pkg; drives the datapath through cmd_t, reads stat_t.
module taqs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  input  taqs_pkg::stat_t stat_i,
  output taqs_pkg::cmd_t  cmd_o
);
  import taqs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = stat_i.need_fetch ? ST_FETCH : ST_SEND;
        end
      end
      ST_FETCH:   state_d = stat_i.was_start ? ST_ISSUE : ST_EVAL;
      ST_EVAL:    state_d = stat_i.advance ? ST_REFETCH : ST_SEND;
      ST_REFETCH: state_d = ST_ISSUE;
      ST_ISSUE:   state_d = ST_SEND;
      ST_SEND: begin
        if (m_ready_i && stat_i.final_res) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  assign s_ready_o   = (state_q == ST_IDLE);
  assign m_valid_o   = (state_q == ST_SEND);
  assign cmd_o.take  = s_ready_o && s_valid_i;
  assign cmd_o.eval  = (state_q == ST_EVAL);
  assign cmd_o.issue = (state_q == ST_ISSUE);
  assign cmd_o.pop   = m_valid_o && m_ready_i;

endmodule

// ----- design/taqs_dp.sv -----
`timescale 1ns / 1ps
// Datapath: action queue memory, ring pointers, run state, elapsed
// counter and two-deep result buffer. Depends on taqs_pkg.
module taqs_dp #(
  parameter int unsigned QUEUE_DEPTH = taqs_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  taqs_pkg::cmd_t               cmd_i,
  output taqs_pkg::stat_t              stat_o,
  input  logic [taqs_pkg::KindW-1:0]   in_kind_i,
  input  logic [taqs_pkg::SDataW-1:0]  in_data_i,
  output logic [taqs_pkg::CmdW-1:0]    out_cmd_o,
  output logic [taqs_pkg::MDataW-1:0]  out_data_o
);
  import taqs_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic signed [ArgW-1:0] a1;
    logic signed [ArgW-1:0] a2;
    logic signed [ArgW-1:0] a3;
    logic                   acc;
  } res_t;

  localparam res_t ResNone = '{cmd: CMD_NONE, a1: '0, a2: '0, a3: '0, acc: 1'b0};
  localparam res_t ResStop = '{cmd: CMD_STOP, a1: '0, a2: '0, a3: '0, acc: 1'b0};

  // queue memory, entry = {duration, arg_three, arg_two, arg_one, type}
  logic [EntryW-1:0] mem_q [QUEUE_DEPTH];
  logic [EntryW-1:0] rd_q;
  logic              we;

  logic [PtrW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic            running_q, running_d, in_delay_q, in_delay_d;
  logic [DurW-1:0] elapsed_q, elapsed_d;
  logic [KindW-1:0] kind_q;
  res_t            res_q [2];
  res_t            res_d [2];
  logic [1:0]      cnt_q, cnt_d;
  logic            idx_q, idx_d;

  // head entry fields
  logic [ActW-1:0]        hd_type;
  logic [DurW-1:0]        hd_dur;
  logic signed [ArgW-1:0] hd_a1, hd_a2, hd_a3;

  logic [PtrW-1:0] wptr_nxt, rptr_nxt;
  logic            empty, full, start_ok;
  logic [DurW-1:0] el_inc;
  logic            done, move_end, drains;
  logic            last_idx;

  assign {hd_dur, hd_a3, hd_a2, hd_a1, hd_type} = rd_q;

  assign wptr_nxt = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
  assign rptr_nxt = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
  assign empty    = (rptr_q == wptr_q);
  assign full     = (wptr_nxt == rptr_q);
  assign start_ok = !running_q && !empty;

  assign el_inc   = (elapsed_q == {DurW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
  assign done     = (el_inc >= hd_dur) && (in_delay_q || (hd_dur != '0));
  assign move_end = done && !in_delay_q && (hd_type == ACT_MOVE);
  assign drains   = done && (rptr_nxt == wptr_q);

  assign we = cmd_i.take && (in_kind_i == KIND_ENQUEUE) && !full;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wptr_q] <= in_data_i[EntryW-1:0];
    end
    rd_q <= mem_q[rptr_q];
  end

  always_comb begin
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    running_d  = running_q;
    in_delay_d = in_delay_q;
    elapsed_d  = elapsed_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;

    if (cmd_i.take) begin
      unique case (in_kind_i)
        KIND_CLEAR: begin
          rptr_d     = '0;
          wptr_d     = '0;
          running_d  = 1'b0;
          in_delay_d = 1'b0;
          res_d[0]   = ResStop;
          cnt_d      = 2'd1;
        end
        KIND_ENQUEUE: begin
          if (!full) begin
            wptr_d       = wptr_nxt;
            res_d[0]     = ResNone;
            res_d[0].acc = 1'b1;
            cnt_d        = 2'd1;
          end
        end
        KIND_START: begin
          if (start_ok) begin
            running_d  = 1'b1;
            in_delay_d = 1'b0;
          end
        end
        default: ;  // tick: handled once the head entry is read
      endcase
    end

    if (cmd_i.eval) begin
      elapsed_d = el_inc;
      if (done) begin
        in_delay_d = 1'b0;
        rptr_d     = rptr_nxt;
        if (move_end) begin
          res_d[0] = ResStop;
        end
        if (drains) begin
          running_d = 1'b0;
          res_d[move_end] = ResStop;
        end
        cnt_d = {1'b0, move_end} + {1'b0, drains};
      end
    end

    if (cmd_i.issue) begin
      elapsed_d = '0;
      unique case (hd_type)
        ACT_MOVE: begin
          res_d[cnt_q[0]] = '{cmd: CMD_MOVE, a1: hd_a1, a2: hd_a2, a3: hd_a3, acc: 1'b0};
          cnt_d           = cnt_q + 1'b1;
        end
        ACT_STOP: begin
          res_d[cnt_q[0]] = ResStop;
          cnt_d           = cnt_q + 1'b1;
        end
        ACT_SERVO: begin
          res_d[cnt_q[0]] = '{cmd: CMD_SERVO, a1: hd_a1, a2: hd_a2, a3: '0, acc: 1'b0};
          cnt_d           = cnt_q + 1'b1;
        end
        default: in_delay_d = 1'b1;
      endcase
    end

    if (cmd_i.pop) begin
      if (idx_q == last_idx) begin
        res_d[0] = ResNone;
        res_d[1] = ResNone;
        cnt_d    = 2'd0;
        idx_d    = 1'b0;
      end else begin
        idx_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q     <= '0;
      wptr_q     <= '0;
      running_q  <= 1'b0;
      in_delay_q <= 1'b0;
      elapsed_q  <= '0;
      res_q[0]   <= ResNone;
      res_q[1]   <= ResNone;
      cnt_q      <= 2'd0;
      idx_q      <= 1'b0;
    end else begin
      rptr_q     <= rptr_d;
      wptr_q     <= wptr_d;
      running_q  <= running_d;
      in_delay_q <= in_delay_d;
      elapsed_q  <= elapsed_d;
      res_q      <= res_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= in_kind_i;
    end
  end

  // an item with no pushed result still shows one "none" result
  assign last_idx = (cnt_q == 2'd2);

  assign stat_o.need_fetch = ((in_kind_i == KIND_START) && start_ok) ||
                             ((in_kind_i == KIND_TICK) && running_q);
  assign stat_o.was_start  = (kind_q == KIND_START);
  assign stat_o.advance    = done && !drains;
  assign stat_o.final_res  = (idx_q == last_idx);

  assign out_cmd_o  = res_q[idx_q].cmd;
  assign out_data_o = {{(MDataW - 3 * ArgW - 2){1'b0}}, running_q, res_q[idx_q].acc,
                       res_q[idx_q].a3, res_q[idx_q].a2, res_q[idx_q].a1};

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> !empty)
    else $error("run in progress with an empty queue");

  a_delay_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_delay_q |-> running_q)
    else $error("delay pending outside a run");

  a_acc_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q[idx_q].acc |-> (res_q[idx_q].cmd == CMD_NONE))
    else $error("accepted flag on an issued command");

endmodule

// ----- design/timed_action_queue_sequencer_top.sv -----
`timescale 1ns / 1ps
// Timed action queue sequencer, top level. Clear, enqueue, idle tick or
// ignored start go straight to the result; a start fetches and issues
// the head entry; a tick in a run fetches and evaluates it, then refetches
// and issues the next entry when it advances. One item at a time, paced
// by the registered queue read and the buffer draining one per cycle on tready.
// Reset (rst_ni low, asynchronous) empties the queue and ends any run.
module timed_action_queue_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = taqs_pkg::QueueDepthDefault  // ring holds DEPTH-1 entries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata, low bit up: action_type[1:0], arg_one[17:2], arg_two[33:18],
  // arg_three[49:34], duration_ms[65:50], zero pad[71:66]
  input  logic [taqs_pkg::SDataW-1:0] s_axis_tdata,
  // tuser: kind[1:0] (tick, clear, enqueue, start)
  input  logic [taqs_pkg::KindW-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata, low bit up: out_arg_one[15:0], out_arg_two[31:16],
  // out_arg_three[47:32], accepted[48], busy_res[49], zero pad[55:50]
  output logic [taqs_pkg::MDataW-1:0] m_axis_tdata,
  // tuser: command[1:0] (none, move, stop, servo)
  output logic [taqs_pkg::CmdW-1:0]   m_axis_tuser,
  // tlast: last result of the input transaction
  output logic                        m_axis_tlast
);
  import taqs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: idle / fetch / evaluate / refetch / issue / send sequence.
  taqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Datapath: queue memory, pointers, elapsed counter, result buffer.
  taqs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_kind_i  (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_cmd_o  (m_axis_tuser),
    .out_data_o (m_axis_tdata)
  );

  // The result on show is the last one once the buffer index reaches its end.
  assign m_axis_tlast = stat.final_res;

endmodule
